// ===== rtl/core/cld_pkg.sv =====
// ============================================================================
// cld_pkg: shared types and constants of the circular list delete engine
// Transaction structs, command and status codes, controller states and the
// command and status groups between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps

package cld_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 2'd0,
    CMD_DEL_FIRST = 2'd1,
    CMD_DEL_LAST  = 2'd2,
    CMD_DEL_POS   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_BAD_POS = 2'd2,
    STS_FULL    = 2'd3
  } status_code_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    status_code_t               status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic        [COUNT_W-1:0]  node_count;
  } rsp_t;

  // What the decoded command needs from the list.
  typedef enum logic [1:0] {
    RT_DONE,
    RT_APPEND,
    RT_DROP_FIRST,
    RT_DROP_AFTER
  } route_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_AP_READ,
    ST_AP_WRITE,
    ST_AP_LINK,
    ST_DF_READ,
    ST_DF_UNLINK,
    ST_DA_START,
    ST_DA_WALK,
    ST_DA_UNLINK,
    ST_RELEASE,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECODE,
    OP_AP_READ,
    OP_AP_WRITE,
    OP_AP_LINK,
    OP_DF_READ,
    OP_DF_UNLINK,
    OP_DA_START,
    OP_DA_WALK,
    OP_DA_UNLINK,
    OP_RELEASE,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    route_t route;
    logic   list_empty;
    logic   walk_done;
    logic   rsp_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/cld_ram.sv =====
// ============================================================================
// cld_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ============================================================================
`timescale 1ns / 1ps

module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cld_ctrl.sv =====
// ============================================================================
// cld_ctrl: command sequencer of the circular list delete engine
// Steps each transaction through decode, the list update and the result.
// ============================================================================
`timescale 1ns / 1ps

module cld_ctrl
  import cld_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.route)
          RT_APPEND:     state_next = ST_AP_READ;
          RT_DROP_FIRST: state_next = ST_DF_READ;
          RT_DROP_AFTER: state_next = ST_DA_START;
          default:       state_next = ST_FINISH;
        endcase
      end
      ST_AP_READ:   state_next = ST_AP_WRITE;
      ST_AP_WRITE:  state_next = stat.list_empty ? ST_FINISH : ST_AP_LINK;
      ST_AP_LINK:   state_next = ST_FINISH;
      ST_DF_READ:   state_next = ST_DF_UNLINK;
      ST_DF_UNLINK: state_next = ST_RELEASE;
      ST_DA_START:  state_next = ST_DA_WALK;
      ST_DA_WALK: begin
        if (stat.walk_done) begin
          state_next = ST_DA_UNLINK;
        end
      end
      ST_DA_UNLINK: state_next = ST_RELEASE;
      ST_RELEASE:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (stat.rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.op    = req_valid ? OP_LOAD : OP_NONE;
      end
      ST_DECODE:    cmd.op = OP_DECODE;
      ST_AP_READ:   cmd.op = OP_AP_READ;
      ST_AP_WRITE:  cmd.op = OP_AP_WRITE;
      ST_AP_LINK:   cmd.op = OP_AP_LINK;
      ST_DF_READ:   cmd.op = OP_DF_READ;
      ST_DF_UNLINK: cmd.op = OP_DF_UNLINK;
      ST_DA_START:  cmd.op = OP_DA_START;
      ST_DA_WALK:   cmd.op = OP_DA_WALK;
      ST_DA_UNLINK: cmd.op = OP_DA_UNLINK;
      ST_RELEASE:   cmd.op = OP_RELEASE;
      ST_FINISH:    cmd.op = stat.rsp_free ? OP_RESULT : OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // A transaction taken in is always decoded in the following cycle.
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == ST_DECODE)
    else $error("accepted transaction was not decoded");

  // A rejected command finishes without touching the list.
  a_reject_finishes: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECODE && stat.route == RT_DONE |=> state == ST_FINISH)
    else $error("rejected command entered a list update");

endmodule

// ===== rtl/core/cld_datapath.sv =====
// ============================================================================
// cld_datapath: list registers, node memories and result register
// Holds the list ends, the free chain head and the node count, and performs
// the memory reads and writes that the controller sequences.
// ============================================================================
`timescale 1ns / 1ps

module cld_datapath
  import cld_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  // Latched transaction.
  cmd_t               op_cmd;
  logic [VALUE_W-1:0] op_value;
  logic [POS_W-1:0]   op_pos;

  // List state.
  logic [IW-1:0] first_node;
  logic [IW-1:0] last_node;
  logic [IW-1:0] free_top;
  logic [CW-1:0] list_length;
  logic [CW-1:0] high_water;

  // Work registers.
  logic [IW-1:0]      cursor;
  logic [IW-1:0]      victim;
  logic [CW-1:0]      walk_cnt;
  status_code_t       status;
  logic [VALUE_W-1:0] removed;
  rsp_t               rsp_q;

  // Memory ports.
  logic               lk_we;
  logic [IW-1:0]      lk_waddr;
  logic [IW-1:0]      lk_wdata;
  logic [IW-1:0]      lk_raddr;
  logic [IW-1:0]      lk_rdata;
  logic               vr_we;
  logic [IW-1:0]      vr_raddr;
  logic [VALUE_W-1:0] vr_rdata;

  // Decode.
  route_t        route;
  status_code_t  dec_status;
  logic [CW-1:0] steps;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] len_ext;
  logic          list_empty;

  // Free chain.
  logic          fresh;
  logic [IW-1:0] free_inc;
  logic [IW-1:0] next_free;

  assign list_empty = (list_length == '0);
  assign pos_ext    = CMPW'(op_pos);
  assign len_ext    = CMPW'(list_length);

  always_comb begin
    route      = RT_DONE;
    dec_status = STS_OK;
    steps      = '0;
    unique case (op_cmd)
      CMD_APPEND: begin
        if (list_length == CAP_CNT) begin
          dec_status = STS_FULL;
        end else begin
          route = RT_APPEND;
        end
      end
      CMD_DEL_FIRST: begin
        if (list_empty) begin
          dec_status = STS_EMPTY;
        end else begin
          route = RT_DROP_FIRST;
        end
      end
      CMD_DEL_LAST: begin
        if (list_empty) begin
          dec_status = STS_EMPTY;
        end else if (list_length == CW'(1)) begin
          route = RT_DROP_FIRST;
        end else begin
          route = RT_DROP_AFTER;
          steps = list_length - CW'(2);
        end
      end
      CMD_DEL_POS: begin
        if (op_pos == '0 || pos_ext > len_ext) begin
          dec_status = STS_BAD_POS;
        end else if (op_pos == POS_W'(1)) begin
          route = RT_DROP_FIRST;
        end else begin
          route = RT_DROP_AFTER;
          steps = CW'(pos_ext - CMPW'(2));
        end
      end
      default: ;
    endcase
  end

  // Nodes at or above the high-water mark were never allocated, so the
  // free chain runs on to the next index rather than through their link.
  assign fresh     = (CW'(free_top) >= high_water);
  assign free_inc  = (free_top == LAST_IDX) ? '0 : free_top + 1'b1;
  assign next_free = fresh ? free_inc : lk_rdata;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = victim;
    lk_wdata = free_top;
    lk_raddr = lk_rdata;
    vr_we    = 1'b0;
    vr_raddr = lk_rdata;
    case (cmd.op)
      OP_AP_READ: begin
        lk_raddr = free_top;
      end
      OP_AP_WRITE: begin
        lk_we    = 1'b1;
        lk_waddr = free_top;
        lk_wdata = list_empty ? free_top : first_node;
        vr_we    = 1'b1;
      end
      OP_AP_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = last_node;
        lk_wdata = victim;
      end
      OP_DF_READ: begin
        lk_raddr = first_node;
        vr_raddr = first_node;
      end
      OP_DF_UNLINK: begin
        lk_we    = (list_length != CW'(1));
        lk_waddr = last_node;
        lk_wdata = lk_rdata;
      end
      OP_DA_START: begin
        lk_raddr = first_node;
      end
      OP_DA_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = cursor;
        lk_wdata = lk_rdata;
      end
      OP_RELEASE: begin
        lk_we    = 1'b1;
        lk_waddr = victim;
        lk_wdata = free_top;
      end
      default: ;
    endcase
  end

  cld_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  cld_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (vr_we),
    .waddr (free_top),
    .wdata (op_value),
    .raddr (vr_raddr),
    .rdata (vr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_node  <= '0;
      last_node   <= '0;
      free_top    <= '0;
      list_length <= '0;
      high_water  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      case (cmd.op)
        OP_AP_WRITE: begin
          free_top <= next_free;
          if (fresh) begin
            high_water <= high_water + 1'b1;
          end
          if (list_empty) begin
            first_node  <= free_top;
            last_node   <= free_top;
            list_length <= list_length + 1'b1;
          end
        end
        OP_AP_LINK: begin
          last_node   <= victim;
          list_length <= list_length + 1'b1;
        end
        OP_DF_UNLINK: begin
          if (list_length == CW'(1)) begin
            first_node  <= '0;
            last_node   <= '0;
            list_length <= '0;
          end else begin
            first_node  <= lk_rdata;
            list_length <= list_length - 1'b1;
          end
        end
        OP_DA_UNLINK: begin
          if (victim == last_node) begin
            last_node <= cursor;
          end
          list_length <= list_length - 1'b1;
        end
        OP_RELEASE: begin
          free_top <= victim;
        end
        default: ;
      endcase

      if (cmd.op == OP_RESULT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        op_cmd   <= req.command;
        op_value <= req.value;
        op_pos   <= req.position;
      end
      OP_DECODE: begin
        status   <= dec_status;
        removed  <= '0;
        walk_cnt <= steps;
      end
      OP_AP_WRITE: begin
        victim <= free_top;
      end
      OP_DF_READ: begin
        victim <= first_node;
      end
      OP_DA_START: begin
        cursor <= first_node;
      end
      OP_DA_WALK: begin
        if (walk_cnt != '0) begin
          cursor   <= lk_rdata;
          walk_cnt <= walk_cnt - 1'b1;
        end else begin
          victim <= lk_rdata;
        end
      end
      OP_DF_UNLINK, OP_DA_UNLINK: begin
        removed <= vr_rdata;
      end
      OP_RESULT: begin
        rsp_q.status        <= status;
        rsp_q.removed_value <= removed;
        rsp_q.node_count    <= COUNT_W'(list_length);
      end
      default: ;
    endcase
  end

  assign rsp = rsp_q;

  assign stat.route      = route;
  assign stat.list_empty = list_empty;
  assign stat.walk_done  = (walk_cnt == '0);
  assign stat.rsp_free   = !rsp_valid || !rsp_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    list_length <= CAP_CNT)
    else $error("node count exceeds the pool");

  // Every list node was allocated at some point, so lies below the mark.
  a_count_water: assert property (@(posedge clk) disable iff (rst)
    list_length <= high_water)
    else $error("node count above the high-water mark");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DA_WALK && walk_cnt != '0 |=> walk_cnt == CW'($past(walk_cnt) - 1'b1))
    else $error("walk counter did not advance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> cmd.op != OP_RESULT)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/circular_list_delete_engine.sv =====
// ============================================================================
// circular_list_delete_engine: circular singly linked list over a node pool
// Request channel (req_valid, req_stall, req) carries one command per
// transaction: append a value, delete the first node, delete the last node or
// delete at a 1-based position. The response channel (rsp_valid, rsp_stall,
// rsp) returns exactly one transaction per command with the status, the
// removed value (zero when nothing was removed) and the node count after it.
// Commands are processed one at a time. A delete that walks follows steps
// links from the first node, where steps is position - 2, or count - 2 for
// delete last, at most CAPACITY - 2. The next request can be taken in the
// cycle after the response is loaded. The walk through the link memory, one
// link per cycle, makes a walking delete the longest command.
// A response held by rsp_stall sits in the output register while the next
// command runs; that command then waits for the register before it finishes.
// Synchronous reset empties the list and chains every node on the free list;
// no clearing pass is needed, as never-allocated nodes are tracked with a
// high-water mark. The node value memory is not cleared.
// ============================================================================
`timescale 1ns / 1ps

module circular_list_delete_engine
  import cld_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Command and status groups between the sequencer and the datapath.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // The sequencer owns the request handshake and the order of memory work.
  cld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // The datapath owns the list registers, both node memories and the
  // response register, so the response side is fully registered.
  cld_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

endmodule

// ===== sim/tb.sv =====
// ============================================================================
// tb: self-checking testbench of the circular list delete engine
// Drives commands over the request channel and compares every response with
// a predictor of the list that is kept in the testbench: node pool, free
// chain, list ends and count. Directed tests cover the empty list, single
// node deletes, walking deletes and the full pool. Random traffic follows.
// It runs under several idle and stall mixes and one long output hold.
// ============================================================================
`timescale 1ns / 1ps

module tb
  import cld_pkg::*;
();

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int IDX_W       = $clog2(CAPACITY);
  // This limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 300000;
  // Longest command plus one held response, with room to spare.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;

  typedef logic [IDX_W-1:0] node_idx_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  circular_list_delete_engine #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Run controls shared between the stimulus and the response stall process.
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_cycles_req = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  // Responses the list should produce, oldest first.
  rsp_t expected_rsps[$];

  // --------------------------------------------------------------------------
  // List predictor. The pool mirrors the block: a value and a next link per
  // node, with unused nodes chained from free_head. Indices are IDX_W bits
  // wide, so every link stays inside the pool by construction.
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] pool_value [CAPACITY];
  node_idx_t          pool_link  [CAPACITY];
  node_idx_t          head_node;
  node_idx_t          tail_node;
  node_idx_t          free_head;
  logic [COUNT_W-1:0] list_len;

  // A removed node goes back on top of the free chain.
  function automatic void push_free(node_idx_t n);
    pool_link[n] = free_head;
    free_head    = n;
  endfunction

  // Follows the given number of links from the head.
  function automatic node_idx_t hop(int unsigned steps);
    node_idx_t n;
    n = head_node;
    repeat (steps) n = pool_link[n];
    return n;
  endfunction

  function automatic logic [VALUE_W-1:0] unlink_head();
    node_idx_t          n;
    logic [VALUE_W-1:0] v;
    n = head_node;
    v = pool_value[n];
    if (list_len <= 1) begin
      list_len  = '0;
      head_node = '0;
      tail_node = '0;
    end else begin
      head_node            = pool_link[n];
      pool_link[tail_node] = head_node;
      list_len             = list_len - 1'b1;
    end
    push_free(n);
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] unlink_after(node_idx_t prev);
    node_idx_t          n;
    logic [VALUE_W-1:0] v;
    n = pool_link[prev];
    v = pool_value[n];
    pool_link[prev] = pool_link[n];
    if (n == tail_node) tail_node = prev;
    list_len = list_len - 1'b1;
    push_free(n);
    return v;
  endfunction

  // A lone node is removed like the head; otherwise walk to the second-last.
  function automatic logic [VALUE_W-1:0] unlink_tail();
    if (list_len <= 1) return unlink_head();
    return unlink_after(hop(list_len - 2));
  endfunction

  // Applies one command to the predicted list and returns its response.
  function automatic rsp_t predict_response(req_t item);
    rsp_t      r;
    node_idx_t n;
    r = '0;
    r.status = STS_OK;
    case (item.command)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          n             = free_head;
          free_head     = pool_link[n];
          pool_value[n] = item.value;
          if (list_len == 0) head_node = n;
          else pool_link[tail_node] = n;
          tail_node    = n;
          pool_link[n] = head_node;
          list_len     = list_len + 1'b1;
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST: begin
        if (list_len == 0) r.status = STS_EMPTY;
        else if (item.command == CMD_DEL_FIRST) r.removed_value = unlink_head();
        else r.removed_value = unlink_tail();
      end
      default: begin
        if (item.position < 1 || item.position > list_len) r.status = STS_BAD_POS;
        else if (item.position == 1) r.removed_value = unlink_head();
        else if (item.position == list_len) r.removed_value = unlink_tail();
        else r.removed_value = unlink_after(hop(item.position - 2));
      end
    endcase
    r.node_count = list_len;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking and reporting.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
    $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
    error_count++;
  endtask

  // Every accepted response transaction is compared with the oldest
  // expectation. Both rsp_valid and rsp_stall are sampled at the edge, so the
  // values seen are the ones the block acted on.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", '0, rsp.removed_value);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", VALUE_W'(want.status), VALUE_W'(rsp.status));
        if (rsp.removed_value !== want.removed_value)
          report_mismatch("removed_value", want.removed_value, rsp.removed_value);
        if (rsp.node_count !== want.node_count)
          report_mismatch("node_count", VALUE_W'(want.node_count),
                          VALUE_W'(rsp.node_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Response side. Normally stall is random at stall_pct; a hold request
  // forces a long unbroken stall, counted here so the sender can keep going.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        hold_left       = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. The task is entered at a rising edge and returns at the
  // edge that accepts the transaction, with valid still high so that the
  // next call can keep it up or drop it for idle cycles.
  // --------------------------------------------------------------------------
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsps.push_back(predict_response(item));
  endtask

  function automatic req_t make_req(cmd_t c, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    req_t r;
    r.command  = c;
    r.value    = v;
    r.position = p;
    return r;
  endfunction

  // Random data with the extremes mixed in now and then.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Drops valid so the last accepted transaction is not offered again, then
  // waits for every outstanding response.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Deletes on an empty list, invalid positions, and a lone node removed
  // from the end and by position one.
  task automatic test_empty_and_single();
    send_request(make_req(CMD_DEL_FIRST, $urandom, '0));
    send_request(make_req(CMD_DEL_LAST, $urandom, '0));
    send_request(make_req(CMD_DEL_POS, '0, 5'd0));
    send_request(make_req(CMD_DEL_POS, '0, 5'd1));
    send_request(make_req(CMD_DEL_POS, '0, 5'd31));
    send_request(make_req(CMD_APPEND, 32'h7fff_ffff, 5'd31));
    send_request(make_req(CMD_DEL_LAST, '0, '0));
    send_request(make_req(CMD_APPEND, 32'h8000_0000, '0));
    send_request(make_req(CMD_DEL_POS, '0, 5'd1));
  endtask

  // Middle deletes that walk, position equal to the count, and a list
  // shrinking back to empty through every delete form.
  task automatic test_walk_deletes();
    send_request(make_req(CMD_APPEND, '1, '0));
    send_request(make_req(CMD_APPEND, '0, '0));
    send_request(make_req(CMD_APPEND, 32'h0000_0005, '0));
    send_request(make_req(CMD_APPEND, 32'h0000_0006, '0));
    send_request(make_req(CMD_DEL_POS, '0, 5'd5));
    send_request(make_req(CMD_DEL_POS, '0, 5'd3));
    send_request(make_req(CMD_DEL_POS, '0, 5'd3));
    send_request(make_req(CMD_DEL_LAST, '0, '0));
    send_request(make_req(CMD_DEL_FIRST, '0, '0));
  endtask

  // Fills the pool, tries one more append and a position past the count, then
  // deletes with long walks so the free chain gets reused out of order.
  task automatic test_pool_full();
    repeat (CAPACITY) send_request(make_req(CMD_APPEND, pick_value(), '0));
    send_request(make_req(CMD_APPEND, $urandom, '0));
    send_request(make_req(CMD_DEL_LAST, '0, '0));
    send_request(make_req(CMD_DEL_POS, '0, 5'(CAPACITY - 2)));
    send_request(make_req(CMD_DEL_POS, '0, 5'(CAPACITY - 1)));
    send_request(make_req(CMD_DEL_FIRST, '0, '0));
    send_request(make_req(CMD_APPEND, pick_value(), '0));
  endtask

  // Mostly well-formed traffic that steers the list toward a target length
  // picked afresh every so often, so short and full lists both get long
  // runs. About one transaction in ten is arbitrary noise.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall);
    int unsigned target;
    req_t        item;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    target        = $urandom_range(CAPACITY);
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 25 == 0) target = $urandom_range(CAPACITY);
      if ($urandom_range(99) < 10) begin
        item = make_req(cmd_t'($urandom_range(3)), $urandom, POS_W'($urandom_range(31)));
      end else if (list_len < target || (list_len == target && $urandom_range(1))) begin
        item = make_req(CMD_APPEND, pick_value(), POS_W'($urandom_range(31)));
      end else if (list_len == 0) begin
        item = make_req(cmd_t'($urandom_range(1, 3)), $urandom, POS_W'($urandom_range(31)));
      end else begin
        case ($urandom_range(2))
          0:       item = make_req(CMD_DEL_FIRST, $urandom, POS_W'($urandom_range(31)));
          1:       item = make_req(CMD_DEL_LAST, $urandom, POS_W'($urandom_range(31)));
          default: item = make_req(CMD_DEL_POS, $urandom,
                                   POS_W'($urandom_range(1, list_len)));
        endcase
      end
      send_request(item);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output register and the command in flight back up into req_stall.
  task automatic test_output_hold();
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_cycles_req = 200;
    repeat (12) begin
      send_request(make_req(list_len < CAPACITY / 2 ? CMD_APPEND : CMD_DEL_LAST,
                            pick_value(), '0));
    end
  endtask

  // The sender waits for every outstanding response before resuming.
  task automatic test_pause_to_drain();
    send_idle_pct = 19;
    stall_pct     = 19;
    wait_drained();
    repeat (8) send_request(make_req(cmd_t'($urandom_range(3)), pick_value(),
                                     POS_W'($urandom_range(1, CAPACITY))));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Predictor reset: empty list, every node on the free chain from node 0.
    for (int i = 0; i < CAPACITY; i++) begin
      pool_value[i] = '0;
      pool_link[i]  = (i + 1 < CAPACITY) ? node_idx_t'(i + 1) : '0;
    end
    head_node = '0;
    tail_node = '0;
    free_head = '0;
    list_len  = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_single();
    test_walk_deletes();
    test_pool_full();
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 86, 0);
    test_random_traffic(100, 0, 86);
    test_random_traffic(100, 19, 19);
    test_output_hold();
    test_pause_to_drain();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cld_pkg.sv
rtl/core/cld_ram.sv
rtl/core/cld_ctrl.sv
rtl/core/cld_datapath.sv
rtl/core/circular_list_delete_engine.sv
sim/tb.sv
